>>> rtl/core/tcpf_pkg.sv
// tcpf_pkg: shared types, widths and codes of the three-class priority fifo
// depends on nothing; used by every module under rtl/core except tcpf_ram
package tcpf_pkg;

    // queue depths and payload size
    localparam int RX_DEPTH      = 16;
    localparam int ST_DEPTH      = 16;
    localparam int ER_DEPTH      = 16;
    localparam int PAYLOAD_BYTES = 8;

    // fixed field widths
    localparam int DATA_W  = 64;
    localparam int LEN_W   = 4;
    localparam int ENTRY_W = LEN_W + DATA_W;

    // pointer widths
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int ST_AW = $clog2(ST_DEPTH);
    localparam int ER_AW = $clog2(ER_DEPTH);

    // command queue between front and back
    localparam int CQ_DEPTH = 2;
    localparam int CQ_AW    = $clog2(CQ_DEPTH);
    localparam int CQ_CW    = $clog2(CQ_DEPTH + 1);

    // result queue at the output
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = $clog2(RQ_DEPTH);
    localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

    // command bit
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef enum logic [1:0] {
        Q_RX = 2'd0,
        Q_ST = 2'd1,
        Q_ER = 2'd2
    } t_qid;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADSEL = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_BADSEL = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        t_qid              queue;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_cmd;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_entry;

    typedef struct packed {
        t_status           status;
        t_qid              queue;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } t_res;

    // length clipped to the payload size
    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(PAYLOAD_BYTES);
        sat_len = (len > lim) ? lim : len;
    endfunction

    // bytes at or above the length cleared
    function automatic logic [DATA_W-1:0] mask_bytes(input logic [DATA_W-1:0] data,
                                                     input logic [LEN_W-1:0]  len);
        logic [DATA_W-1:0] res;
        res = '0;
        for (int b = 0; b < DATA_W / 8; b++) begin
            if (LEN_W'(b) < len) begin
                res[b*8 +: 8] = data[b*8 +: 8];
            end
        end
        mask_bytes = res;
    endfunction

endpackage

>>> rtl/core/tcpf_ram.sv
// tcpf_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module tcpf_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/tcpf_front.sv
// tcpf_front: accepts commands, classifies them and holds them in a short queue
// depends on tcpf_pkg
module tcpf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_push,
    output logic                              o_full,
    input  logic                              i_cmd,
    input  logic [1:0]                        i_queue_select,
    input  logic [tcpf_pkg::DATA_W-1:0]       i_payload_data,
    input  logic [tcpf_pkg::LEN_W-1:0]        i_payload_length,
    input  logic                              i_stream_en,
    output logic                              o_cmd_valid,
    output tcpf_pkg::t_cmd                    o_cmd,
    input  logic                              i_cmd_take
);

    tcpf_pkg::t_cmd                 cls;
    logic [tcpf_pkg::LEN_W-1:0]     len_sat;
    logic                           acc;

    tcpf_pkg::t_cmd                 r_q [tcpf_pkg::CQ_DEPTH];
    logic [tcpf_pkg::CQ_AW-1:0]     r_wptr;
    logic [tcpf_pkg::CQ_AW-1:0]     r_rptr;
    logic [tcpf_pkg::CQ_CW-1:0]     r_count;
    logic [tcpf_pkg::CQ_AW-1:0]     n_wptr;
    logic [tcpf_pkg::CQ_AW-1:0]     n_rptr;
    logic [tcpf_pkg::CQ_CW-1:0]     n_count;

    // classify the incoming command
    always_comb begin
        len_sat   = tcpf_pkg::sat_len(i_payload_length);
        cls.len   = len_sat;
        cls.data  = tcpf_pkg::mask_bytes(i_payload_data, len_sat);
        cls.queue = tcpf_pkg::Q_RX;
        cls.op    = tcpf_pkg::OP_BADSEL;
        if (i_cmd == tcpf_pkg::CMD_READ) begin
            cls.op = tcpf_pkg::OP_READ;
        end else begin
            case (i_queue_select)
                tcpf_pkg::Q_RX: begin
                    cls.op    = tcpf_pkg::OP_WRITE;
                    cls.queue = tcpf_pkg::Q_RX;
                end
                tcpf_pkg::Q_ST: begin
                    if (i_stream_en) begin
                        cls.op    = tcpf_pkg::OP_WRITE;
                        cls.queue = tcpf_pkg::Q_ST;
                    end
                end
                tcpf_pkg::Q_ER: begin
                    cls.op    = tcpf_pkg::OP_WRITE;
                    cls.queue = tcpf_pkg::Q_ER;
                end
                default: begin
                    cls.op = tcpf_pkg::OP_BADSEL;
                end
            endcase
        end
    end

    assign o_full      = (r_count == tcpf_pkg::CQ_CW'(tcpf_pkg::CQ_DEPTH));
    assign acc         = i_push && !o_full;
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rptr];

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (acc) begin
            n_wptr = (r_wptr == tcpf_pkg::CQ_AW'(tcpf_pkg::CQ_DEPTH - 1)) ? '0
                                                                        : r_wptr + 1'b1;
        end
        if (i_cmd_take) begin
            n_rptr = (r_rptr == tcpf_pkg::CQ_AW'(tcpf_pkg::CQ_DEPTH - 1)) ? '0
                                                                        : r_rptr + 1'b1;
        end
        if (acc && !i_cmd_take) begin
            n_count = r_count + 1'b1;
        end else if (!acc && i_cmd_take) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wptr] <= cls;
        end
    end

endmodule

>>> rtl/core/tcpf_back.sv
// tcpf_back: the three ring queues, their pointers and strict-priority service
// depends on tcpf_pkg and tcpf_ram
module tcpf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_stream_en,
    input  logic           i_cmd_valid,
    input  tcpf_pkg::t_cmd i_cmd,
    output logic           o_cmd_take,
    input  logic           i_res_room,
    output logic           o_res_valid,
    output tcpf_pkg::t_res o_res
);

    logic                          exec;

    logic [tcpf_pkg::RX_AW-1:0]    r_rx_head, r_rx_tail, n_rx_head, n_rx_tail;
    logic [tcpf_pkg::ST_AW-1:0]    r_st_head, r_st_tail, n_st_head, n_st_tail;
    logic [tcpf_pkg::ER_AW-1:0]    r_er_head, r_er_tail, n_er_head, n_er_tail;
    logic [tcpf_pkg::RX_AW-1:0]    rx_tail_inc, rx_head_inc;
    logic [tcpf_pkg::ST_AW-1:0]    st_tail_inc, st_head_inc;
    logic [tcpf_pkg::ER_AW-1:0]    er_tail_inc, er_head_inc;
    logic                          rx_full, st_full, er_full;
    logic                          rx_ne, st_ne, er_ne;

    logic                          rx_we, st_we, er_we;
    logic                          rx_re, st_re, er_re;
    tcpf_pkg::t_entry              wentry;
    logic [tcpf_pkg::ENTRY_W-1:0]  rx_rdata, st_rdata, er_rdata;
    tcpf_pkg::t_entry              sel_entry;

    tcpf_pkg::t_status             n_status;
    tcpf_pkg::t_qid                n_queue;
    logic                          n_hit;

    logic                          r_res_valid;
    tcpf_pkg::t_status             r_res_status;
    tcpf_pkg::t_qid                r_res_queue;
    logic                          r_res_hit;

    assign exec       = i_cmd_valid && i_res_room;
    assign o_cmd_take = exec;

    assign rx_tail_inc = (r_rx_tail == tcpf_pkg::RX_AW'(tcpf_pkg::RX_DEPTH - 1)) ? '0
                                                                              : r_rx_tail + 1'b1;
    assign rx_head_inc = (r_rx_head == tcpf_pkg::RX_AW'(tcpf_pkg::RX_DEPTH - 1)) ? '0
                                                                              : r_rx_head + 1'b1;
    assign st_tail_inc = (r_st_tail == tcpf_pkg::ST_AW'(tcpf_pkg::ST_DEPTH - 1)) ? '0
                                                                              : r_st_tail + 1'b1;
    assign st_head_inc = (r_st_head == tcpf_pkg::ST_AW'(tcpf_pkg::ST_DEPTH - 1)) ? '0
                                                                              : r_st_head + 1'b1;
    assign er_tail_inc = (r_er_tail == tcpf_pkg::ER_AW'(tcpf_pkg::ER_DEPTH - 1)) ? '0
                                                                              : r_er_tail + 1'b1;
    assign er_head_inc = (r_er_head == tcpf_pkg::ER_AW'(tcpf_pkg::ER_DEPTH - 1)) ? '0
                                                                              : r_er_head + 1'b1;

    // one slot always left free
    assign rx_full = (rx_tail_inc == r_rx_head);
    assign st_full = (st_tail_inc == r_st_head);
    assign er_full = (er_tail_inc == r_er_head);

    // stream queue skipped while disabled
    assign rx_ne = (r_rx_head != r_rx_tail);
    assign st_ne = (r_st_head != r_st_tail) && i_stream_en;
    assign er_ne = (r_er_head != r_er_tail);

    assign wentry.len  = i_cmd.len;
    assign wentry.data = i_cmd.data;

    always_comb begin
        n_status  = tcpf_pkg::ST_OK;
        n_queue   = tcpf_pkg::Q_RX;
        n_hit     = 1'b0;
        rx_we     = 1'b0;
        st_we     = 1'b0;
        er_we     = 1'b0;
        rx_re     = 1'b0;
        st_re     = 1'b0;
        er_re     = 1'b0;
        n_rx_head = r_rx_head;
        n_rx_tail = r_rx_tail;
        n_st_head = r_st_head;
        n_st_tail = r_st_tail;
        n_er_head = r_er_head;
        n_er_tail = r_er_tail;
        case (i_cmd.op)
            tcpf_pkg::OP_WRITE: begin
                case (i_cmd.queue)
                    tcpf_pkg::Q_RX: begin
                        if (rx_full) begin
                            n_status = tcpf_pkg::ST_FULL;
                        end else begin
                            rx_we     = exec;
                            n_rx_tail = exec ? rx_tail_inc : r_rx_tail;
                        end
                    end
                    tcpf_pkg::Q_ST: begin
                        if (st_full) begin
                            n_status = tcpf_pkg::ST_FULL;
                        end else begin
                            st_we     = exec;
                            n_st_tail = exec ? st_tail_inc : r_st_tail;
                        end
                    end
                    tcpf_pkg::Q_ER: begin
                        if (er_full) begin
                            n_status = tcpf_pkg::ST_FULL;
                        end else begin
                            er_we     = exec;
                            n_er_tail = exec ? er_tail_inc : r_er_tail;
                        end
                    end
                    default: begin
                        n_status = tcpf_pkg::ST_BADSEL;
                    end
                endcase
            end
            tcpf_pkg::OP_READ: begin
                n_hit = 1'b1;
                if (rx_ne) begin
                    n_queue   = tcpf_pkg::Q_RX;
                    rx_re     = exec;
                    n_rx_head = exec ? rx_head_inc : r_rx_head;
                end else if (st_ne) begin
                    n_queue   = tcpf_pkg::Q_ST;
                    st_re     = exec;
                    n_st_head = exec ? st_head_inc : r_st_head;
                end else if (er_ne) begin
                    n_queue   = tcpf_pkg::Q_ER;
                    er_re     = exec;
                    n_er_head = exec ? er_head_inc : r_er_head;
                end else begin
                    n_status = tcpf_pkg::ST_EMPTY;
                    n_hit    = 1'b0;
                end
            end
            default: begin
                n_status = tcpf_pkg::ST_BADSEL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_head   <= '0;
            r_rx_tail   <= '0;
            r_st_head   <= '0;
            r_st_tail   <= '0;
            r_er_head   <= '0;
            r_er_tail   <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_rx_head   <= n_rx_head;
            r_rx_tail   <= n_rx_tail;
            r_st_head   <= n_st_head;
            r_st_tail   <= n_st_tail;
            r_er_head   <= n_er_head;
            r_er_tail   <= n_er_tail;
            r_res_valid <= exec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_res_status <= n_status;
            r_res_queue  <= n_queue;
            r_res_hit    <= n_hit;
        end
    end

    tcpf_ram #(
        .DEPTH (tcpf_pkg::RX_DEPTH),
        .WIDTH (tcpf_pkg::ENTRY_W)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (r_rx_tail),
        .i_wdata (wentry),
        .i_re    (rx_re),
        .i_raddr (r_rx_head),
        .o_rdata (rx_rdata)
    );

    tcpf_ram #(
        .DEPTH (tcpf_pkg::ST_DEPTH),
        .WIDTH (tcpf_pkg::ENTRY_W)
    ) u_st_ram (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_st_tail),
        .i_wdata (wentry),
        .i_re    (st_re),
        .i_raddr (r_st_head),
        .o_rdata (st_rdata)
    );

    tcpf_ram #(
        .DEPTH (tcpf_pkg::ER_DEPTH),
        .WIDTH (tcpf_pkg::ENTRY_W)
    ) u_er_ram (
        .i_clk   (i_clk),
        .i_we    (er_we),
        .i_waddr (r_er_tail),
        .i_wdata (wentry),
        .i_re    (er_re),
        .i_raddr (r_er_head),
        .o_rdata (er_rdata)
    );

    // pick the memory that served the read
    always_comb begin
        case (r_res_queue)
            tcpf_pkg::Q_RX: sel_entry = rx_rdata;
            tcpf_pkg::Q_ST: sel_entry = st_rdata;
            tcpf_pkg::Q_ER: sel_entry = er_rdata;
            default:        sel_entry = rx_rdata;
        endcase
    end

    assign o_res_valid  = r_res_valid;
    assign o_res.status = r_res_status;
    assign o_res.queue  = r_res_hit ? r_res_queue : tcpf_pkg::Q_RX;
    assign o_res.len    = r_res_hit ? sel_entry.len : '0;
    assign o_res.data   = r_res_hit ? sel_entry.data : '0;

    a_res_follows_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> r_res_valid)
        else $error("result missing after executed command");

    a_no_res_without_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !exec |=> !r_res_valid)
        else $error("result without executed command");

    a_rx_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && i_cmd.op == tcpf_pkg::OP_READ && rx_ne) |=>
            (r_res_queue == tcpf_pkg::Q_RX && r_res_status == tcpf_pkg::ST_OK))
        else $error("read skipped a non-empty receive queue");

    a_badsel_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && i_cmd.op == tcpf_pkg::OP_BADSEL) |=>
            ($stable(r_rx_tail) && $stable(r_st_tail) && $stable(r_er_tail)))
        else $error("bad select changed a queue");

endmodule

>>> rtl/core/tcpf_res_fifo.sv
// tcpf_res_fifo: small queue of finished results towards the output ports
// depends on tcpf_pkg
module tcpf_res_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  tcpf_pkg::t_res             i_data,
    input  logic                       i_pop,
    output logic                       o_empty,
    output tcpf_pkg::t_res             o_data,
    output logic [tcpf_pkg::RQ_CW-1:0] o_count
);

    tcpf_pkg::t_res                 r_q [tcpf_pkg::RQ_DEPTH];
    logic [tcpf_pkg::RQ_AW-1:0]     r_wptr, n_wptr;
    logic [tcpf_pkg::RQ_AW-1:0]     r_rptr, n_rptr;
    logic [tcpf_pkg::RQ_CW-1:0]     r_count, n_count;
    logic                           take;

    assign o_empty = (r_count == '0);
    assign o_data  = r_q[r_rptr];
    assign o_count = r_count;
    assign take    = i_pop && !o_empty;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == tcpf_pkg::RQ_AW'(tcpf_pkg::RQ_DEPTH - 1)) ? '0
                                                                        : r_wptr + 1'b1;
        end
        if (take) begin
            n_rptr = (r_rptr == tcpf_pkg::RQ_AW'(tcpf_pkg::RQ_DEPTH - 1)) ? '0
                                                                        : r_rptr + 1'b1;
        end
        if (i_push && !take) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && take) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_data;
        end
    end

endmodule

>>> rtl/core/three_class_priority_fifo_unit.sv
// three_class_priority_fifo_unit: top level of the three-class priority fifo
// throughput: one command per cycle sustained while the result queue has room to take it,
// with one queue pointer and one ram port per command
// reset: synchronous active low; all queues empty, stream queue enabled, rams left as they are
// depends on tcpf_pkg, tcpf_front, tcpf_back, tcpf_res_fifo, tcpf_ram
module three_class_priority_fifo_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // command side
    input  logic                              push,
    output logic                              full,
    input  logic                              i_cmd,
    input  logic [1:0]                        i_queue_select,
    input  logic [tcpf_pkg::DATA_W-1:0]       i_payload_data,
    input  logic [tcpf_pkg::LEN_W-1:0]        i_payload_length,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        o_status,
    output logic [tcpf_pkg::DATA_W-1:0]       o_read_data,
    output logic [tcpf_pkg::LEN_W-1:0]        o_read_length,
    output logic [1:0]                        o_read_queue,
    // configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_data
);

    // stream enable register
    logic                        r_stream_en;

    // front to back command transfer
    logic                        cmd_valid;
    tcpf_pkg::t_cmd              cmd;
    logic                        cmd_take;

    // back to result queue
    logic                        res_valid;
    tcpf_pkg::t_res              res;
    tcpf_pkg::t_res              out_res;
    logic [tcpf_pkg::RQ_CW-1:0]  res_count;
    logic [tcpf_pkg::RQ_CW-1:0]  res_used;
    logic                        res_room;

    // configuration is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stream_en <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_stream_en <= i_cfg_data;
        end
    end

    // front: classify and queue commands
    tcpf_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_cmd            (i_cmd),
        .i_queue_select   (i_queue_select),
        .i_payload_data   (i_payload_data),
        .i_payload_length (i_payload_length),
        .i_stream_en      (r_stream_en),
        .o_cmd_valid      (cmd_valid),
        .o_cmd            (cmd),
        .i_cmd_take       (cmd_take)
    );

    // credit: stored results plus the one in flight must leave a slot free
    assign res_used = res_count + tcpf_pkg::RQ_CW'(res_valid);
    assign res_room = (res_used < tcpf_pkg::RQ_CW'(tcpf_pkg::RQ_DEPTH));

    // back: ring queues and priority service
    tcpf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stream_en (r_stream_en),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_room  (res_room),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // results wait here until popped
    tcpf_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_data  (res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res),
        .o_count (res_count)
    );

    assign o_status      = out_res.status;
    assign o_read_data   = out_res.data;
    assign o_read_length = out_res.len;
    assign o_read_queue  = out_res.queue;

endmodule

>>> tb/sv/tcpf_response_checker.sv
`timescale 1ns / 100ps
// tcpf_response_checker: watches the command, result and configuration channels of
// the three-class priority fifo, predicts every response and compares it field by field
// depends on tcpf_pkg only
module tcpf_response_checker
    import tcpf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic              i_cmd,
    input  logic [1:0]        i_queue_select,
    input  logic [DATA_W-1:0] i_payload_data,
    input  logic [LEN_W-1:0]  i_payload_length,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic [1:0]        i_status,
    input  logic [DATA_W-1:0] i_read_data,
    input  logic [LEN_W-1:0]  i_read_length,
    input  logic [1:0]        i_read_queue,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_data,
    output int                o_pending,
    output int                o_fail_count
);

    localparam int NUM_QUEUES = 3;
    localparam int MAX_DEPTH  = (RX_DEPTH > ST_DEPTH) ?
                                ((RX_DEPTH > ER_DEPTH) ? RX_DEPTH : ER_DEPTH) :
                                ((ST_DEPTH > ER_DEPTH) ? ST_DEPTH : ER_DEPTH);

    logic [DATA_W-1:0] slot_data [NUM_QUEUES][MAX_DEPTH];
    logic [LEN_W-1:0]  slot_len  [NUM_QUEUES][MAX_DEPTH];
    int                rd_ptr    [NUM_QUEUES];
    int                wr_ptr    [NUM_QUEUES];
    bit                stream_on = 1'b1;
    t_res              awaited_responses [$];
    int                fails = 0;

    function automatic int depth_of(input int q);
        case (q)
            Q_RX:    depth_of = RX_DEPTH;
            Q_ST:    depth_of = ST_DEPTH;
            default: depth_of = ER_DEPTH;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] keep_low_bytes(input logic [DATA_W-1:0] data,
                                                         input logic [LEN_W-1:0]  len);
        logic [DATA_W-1:0] mask;
        if (len >= DATA_W / 8) mask = '1;
        else mask = (DATA_W'(1) << (8 * len)) - DATA_W'(1);
        keep_low_bytes = data & mask;
    endfunction

    // one command against the shadow queues; updates them and returns the response
    function automatic t_res predict_response(input logic              cmd,
                                              input logic [1:0]        sel,
                                              input logic [DATA_W-1:0] data,
                                              input logic [LEN_W-1:0]  len);
        t_res             r;
        logic [LEN_W-1:0] clen;
        int               q;
        int               nxt;
        bit               served;
        r = '0;
        r.status = ST_OK;
        r.queue  = Q_RX;
        if (cmd == CMD_WRITE) begin
            clen = (len > PAYLOAD_BYTES) ? LEN_W'(PAYLOAD_BYTES) : len;
            if (sel == Q_RX || sel == Q_ER || (sel == Q_ST && stream_on)) begin
                q   = int'(sel);
                nxt = (wr_ptr[q] + 1) % depth_of(q);
                if (nxt == rd_ptr[q]) begin
                    r.status = ST_FULL;
                end else begin
                    slot_data[q][wr_ptr[q]] = keep_low_bytes(data, clen);
                    slot_len[q][wr_ptr[q]]  = clen;
                    wr_ptr[q] = nxt;
                end
            end else begin
                r.status = ST_BADSEL;
            end
        end else begin
            served = 1'b0;
            for (int k = 0; k < NUM_QUEUES; k++) begin
                if (!served && rd_ptr[k] != wr_ptr[k] && (k != Q_ST || stream_on)) begin
                    served    = 1'b1;
                    r.queue   = t_qid'(k);
                    r.len     = slot_len[k][rd_ptr[k]];
                    r.data    = keep_low_bytes(slot_data[k][rd_ptr[k]], r.len);
                    rd_ptr[k] = (rd_ptr[k] + 1) % depth_of(k);
                end
            end
            if (!served) r.status = ST_EMPTY;
        end
        predict_response = r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns  mismatch: %s", $time, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_QUEUES; k++) begin
                rd_ptr[k] = 0;
                wr_ptr[k] = 0;
            end
            stream_on = 1'b1;
            awaited_responses.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) stream_on = i_cfg_data;
            if (i_pop && !i_empty) begin
                if (awaited_responses.size() == 0) begin
                    report_mismatch($sformatf("result transfer with nothing awaited, status %0d",
                                              i_status));
                end else begin
                    want = awaited_responses.pop_front();
                    if (i_status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                                                  i_status, want.status));
                    if (i_read_data !== want.data)
                        report_mismatch($sformatf("read_data %h, want %h",
                                                  i_read_data, want.data));
                    if (i_read_length !== want.len)
                        report_mismatch($sformatf("read_length %0d, want %0d",
                                                  i_read_length, want.len));
                    if (i_read_queue !== want.queue)
                        report_mismatch($sformatf("read_queue %0d, want %0d",
                                                  i_read_queue, want.queue));
                end
            end
            if (i_push && !i_full)
                awaited_responses.push_back(predict_response(i_cmd, i_queue_select,
                                                             i_payload_data, i_payload_length));
        end
        o_pending    <= awaited_responses.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/sv/tb_three_class_priority_fifo_unit.sv
`timescale 1ns / 100ps
// tb_three_class_priority_fifo_unit: stimulus and verdict for the three-class priority fifo
// depends on tcpf_pkg, three_class_priority_fifo_unit and tcpf_response_checker
module tb_three_class_priority_fifo_unit;
    import tcpf_pkg::*;

    // write target that names no queue
    localparam logic [1:0] SEL_INVALID = 2'd3;
    // long receiver hold-off, enough to fill the command and result buffers
    localparam int HOLD_OFF_CYCLES = 80;
    // margin after the last awaited result
    localparam int SETTLE_CYCLES = 8;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              push             = 1'b0;
    logic              full;
    logic              i_cmd            = CMD_WRITE;
    logic [1:0]        i_queue_select   = 2'd0;
    logic [DATA_W-1:0] i_payload_data   = '0;
    logic [LEN_W-1:0]  i_payload_length = '0;
    logic              empty;
    logic              pop              = 1'b0;
    logic [1:0]        o_status;
    logic [DATA_W-1:0] o_read_data;
    logic [LEN_W-1:0]  o_read_length;
    logic [1:0]        o_read_queue;
    logic              i_cfg_valid      = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data       = 1'b0;

    // idling odds per cycle, changed between phases
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    // raised by the stimulus, cleared by the receiver once it starts holding off
    bit hold_off_request = 1'b0;

    int pending;
    int fail_count;

    always #5 i_clk = ~i_clk;

    three_class_priority_fifo_unit u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_cmd            (i_cmd),
        .i_queue_select   (i_queue_select),
        .i_payload_data   (i_payload_data),
        .i_payload_length (i_payload_length),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_read_data      (o_read_data),
        .o_read_length    (o_read_length),
        .o_read_queue     (o_read_queue),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data)
    );

    tcpf_response_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_full           (full),
        .i_cmd            (i_cmd),
        .i_queue_select   (i_queue_select),
        .i_payload_data   (i_payload_data),
        .i_payload_length (i_payload_length),
        .i_empty          (empty),
        .i_pop            (pop),
        .i_status         (o_status),
        .i_read_data      (o_read_data),
        .i_read_length    (o_read_length),
        .i_read_queue     (o_read_queue),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_data       (i_cfg_data),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("tb_three_class_priority_fifo_unit: done, errors");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request, counted here
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                pop <= 1'b0;
                for (int c = 1; c < HOLD_OFF_CYCLES; c++) @(posedge i_clk);
            end else begin
                pop <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // one command transfer; push stays high on return so back-to-back items need no gap
    task automatic send_command(input logic              cmd,
                                input logic [1:0]        sel,
                                input logic [DATA_W-1:0] data,
                                input logic [LEN_W-1:0]  len);
        while ($urandom_range(99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_cmd            <= cmd;
        i_queue_select   <= sel;
        i_payload_data   <= data;
        i_payload_length <= len;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    // register write only once the unit has drained every awaited result
    task automatic set_stream_enable(input bit enable);
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= enable;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // write-heavy bursts fill the queues up to full, read-heavy ones drain them to empty;
    // focus steers most writes at one queue so that it fills on its own
    task automatic random_burst(input int count, input int write_pct, input int focus);
        logic              c;
        logic [1:0]        s;
        logic [LEN_W-1:0]  l;
        logic [DATA_W-1:0] d;
        for (int n = 0; n < count; n++) begin
            c = ($urandom_range(99) < write_pct) ? CMD_WRITE : CMD_READ;
            if (focus >= 0 && $urandom_range(99) < 60) s = focus[1:0];
            else s = 2'($urandom_range(3));
            // mostly legal lengths, some over-long ones to exercise saturation
            if ($urandom_range(99) < 80) l = LEN_W'($urandom_range(PAYLOAD_BYTES));
            else l = LEN_W'($urandom_range(15, PAYLOAD_BYTES + 1));
            d = {$urandom, $urandom};
            send_command(c, s, d, l);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit enable,
                             input bit squeeze);
        set_stream_enable(enable);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        random_burst(40, 80, Q_RX);
        // receiver goes quiet while the sender keeps offering, so full must assert
        if (squeeze) hold_off_request = 1'b1;
        random_burst(40, 85, Q_ST);
        random_burst(40, 20, -1);
        random_burst(40, 80, Q_ER);
        random_burst(40, 15, -1);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lengths at the extremes, every select, priority order, empty read
        set_stream_enable(1'b1);
        send_command(CMD_WRITE, Q_RX, '1, 4'd0);                   // zero length, stored as zero
        send_command(CMD_WRITE, Q_RX, '1, 4'd8);                   // full payload
        send_command(CMD_WRITE, Q_ST, 64'hfedc_ba98_7654_3210, 4'd9);  // saturates to eight
        send_command(CMD_WRITE, Q_ER, 64'h0123_4567_89ab_cdef, 4'd15);
        send_command(CMD_WRITE, SEL_INVALID, '1, 4'd8);            // bad select, nothing stored
        send_command(CMD_WRITE, Q_ER, 64'h0000_0000_0000_00a5, 4'd1);
        // read with junk in the write fields, which must be ignored
        send_command(CMD_READ, SEL_INVALID, '1, 4'd15);
        send_command(CMD_READ, Q_ER, '0, 4'd0);
        send_command(CMD_READ, Q_RX, 64'h5555_aaaa_5555_aaaa, 4'd3);
        send_command(CMD_READ, Q_ST, '0, 4'd0);
        send_command(CMD_READ, Q_RX, '0, 4'd0);
        send_command(CMD_READ, Q_RX, '0, 4'd0);                    // all queues empty
        send_command(CMD_WRITE, Q_ST, 64'h1122_3344_5566_7788, 4'd4);
        send_command(CMD_WRITE, Q_ER, 64'h99aa_bbcc_ddee_ff00, 4'd3);

        // stream queue disabled: writes to it refused, its entry skipped but kept
        set_stream_enable(1'b0);
        send_command(CMD_WRITE, Q_ST, '1, 4'd8);
        send_command(CMD_READ, Q_RX, '0, 4'd0);
        send_command(CMD_READ, Q_RX, '0, 4'd0);

        // re-enabled: the kept stream entry comes back
        set_stream_enable(1'b1);
        send_command(CMD_READ, Q_RX, '0, 4'd0);
        send_command(CMD_READ, Q_RX, '0, 4'd0);

        // random phases: no idling, sender idle, receiver stalling with a hold-off, both
        run_phase(0, 0, 1'b1, 1'b0);
        run_phase(54, 0, 1'b0, 1'b0);
        run_phase(0, 54, 1'b1, 1'b1);
        run_phase(10, 10, 1'b0, 1'b0);

        // drain, then a margin for any stray result
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("tb_three_class_priority_fifo_unit: done, clean");
        end else begin
            $display("tb_three_class_priority_fifo_unit: done, errors");
        end
        $finish;
    end

endmodule
